### rtl/tilt_angle_from_accel_assert.svh
// assertion macros shared by the tilt angle rtl
`ifndef TILT_ANGLE_FROM_ACCEL_ASSERT_SVH
`define TILT_ANGLE_FROM_ACCEL_ASSERT_SVH

// same-cycle implication
`define TILT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tilt assertion failed");

// next-cycle implication
`define TILT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tilt assertion failed");

`endif

### rtl/tilt_pkg.sv
// types, constants and codes for the tilt angle block
package tilt_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int ANGLE_W     = 17;
   localparam int CSR_W       = 15;
   localparam int CSR_IDX_W   = 1;

   localparam int NORM_W      = 20;
   localparam int ROOT_W      = 24;
   localparam int AT_W        = 26;
   localparam int ANG_W       = 20;
   localparam int DIVD_W      = 40;
   localparam int DIVS_W      = 24;
   localparam int DIV_BITS    = 2;
   localparam int DIV_CYCLES  = DIVD_W / DIV_BITS;

   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int SQRT_STEPS_DEF  = 3;

   localparam int Q_FRAC          = 16;
   localparam int NORM_MAX        = 524287;
   localparam int NORM_MIN_MAG    = 524288;
   localparam int ATAN_C1         = 12865;
   localparam int ATAN_C2         = 64337;
   localparam int QTR_PI_Q        = 51472;
   localparam int THREE_QTR_PI_Q  = 154416;
   localparam int PI_Q            = 205887;
   localparam int HALF_TURN_OUT   = 46080;
   localparam int THRESH_RESET    = 64;
   localparam int CPG_RESET       = 16384;

   // floor(HALF_TURN_OUT * 2^32 / PI_Q), estimate is exact or one low
   localparam int     DEG_SHIFT   = 32;
   localparam longint DEG_RECIP   = (longint'(HALF_TURN_OUT) << DEG_SHIFT) / longint'(PI_Q);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHANGE_THRESHOLD = 1'b0,
      CSR_G_SCALE          = 1'b1
   } tilt_csr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_NORM_DIV,
      S_NORM_WAIT,
      S_SQ_Y,
      S_SQ_Z,
      S_SQRT_DIV,
      S_SQRT_WAIT,
      S_AT_DIV,
      S_AT_WAIT,
      S_AT_R2,
      S_AT_T,
      S_AT_TR,
      S_DEG_MUL,
      S_DEG_REM,
      S_DEG_FIX,
      S_OUT
   } tilt_state_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] y;
      logic signed [SAMPLE_W-1:0] z;
      logic                       changed;
   } tilt_item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } tilt_qstat_type;

endpackage

### rtl/tilt_angle_from_accel.sv
// top level of the accelerometer tilt angle block
// Each accepted sample gives one result item. A sample that moves no axis by
// change_threshold or more returns the held roll and pitch without recomputing.
// A sample that recomputes runs 5 + SQRT_STEPS divisions (three normalizations,
// the square-root steps and two atan2 ratios) through one shared divider that
// retires two quotient bits per cycle; the two degree scalings use a reciprocal
// multiply and one compare and subtract step. A two-entry queue (by default)
// lets samples be accepted while the back end works, and the result register
// lets the next item proceed while a finished one waits. Configuration writes
// take effect at once and are meant for idle periods.
module tilt_angle_from_accel #(
   parameter int SQRT_STEPS  = tilt_pkg::SQRT_STEPS_DEF,
   parameter int QUEUE_DEPTH = tilt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [tilt_pkg::SAMPLE_W-1:0] req_accel_x,
   input  logic signed [tilt_pkg::SAMPLE_W-1:0] req_accel_y,
   input  logic signed [tilt_pkg::SAMPLE_W-1:0] req_accel_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tilt_pkg::ANGLE_W-1:0]  rsp_roll_angle,
   output logic signed [tilt_pkg::ANGLE_W-1:0]  rsp_pitch_angle,
   output logic                                 rsp_recomputed,
   input  logic                                 csr_write_enable,
   input  logic [tilt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tilt_pkg::CSR_W-1:0]           csr_write_data
);
   import tilt_pkg::*;

   logic [CSR_W-1:0] thresh_ff, thresh_in;
   logic [CSR_W-1:0] cpg_ff, cpg_in;

   logic             push, pop;
   tilt_item_type    item, head;
   tilt_qstat_type   qstat;

   always_comb begin
      thresh_in = thresh_ff;
      cpg_in    = cpg_ff;
      if (csr_write_enable) begin
         case (tilt_csr_type'(csr_index))
            CSR_CHANGE_THRESHOLD: thresh_in = csr_write_data;
            CSR_G_SCALE:          cpg_in    = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= CSR_W'(THRESH_RESET);
         cpg_ff    <= CSR_W'(CPG_RESET);
      end else begin
         thresh_ff <= thresh_in;
         cpg_ff    <= cpg_in;
      end
   end

   tilt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_accel_x      (req_accel_x),
      .req_accel_y      (req_accel_y),
      .req_accel_z      (req_accel_z),
      .change_threshold (thresh_ff),
      .qstat            (qstat),
      .push             (push),
      .item             (item)
   );

   tilt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .item  (item),
      .pop   (pop),
      .head  (head),
      .qstat (qstat)
   );

   tilt_back #(
      .SQRT_STEPS (SQRT_STEPS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .g_scale         (cpg_ff),
      .head            (head),
      .qstat           (qstat),
      .pop             (pop),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_roll_angle  (rsp_roll_angle),
      .rsp_pitch_angle (rsp_pitch_angle),
      .rsp_recomputed  (rsp_recomputed)
   );

endmodule

### rtl/tilt_div.sv
// iterative unsigned divider, two quotient bits per cycle
module tilt_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tilt_pkg::DIVD_W-1:0] dividend,
   input  logic [tilt_pkg::DIVS_W-1:0] divisor,
   output logic                       done,
   output logic [tilt_pkg::DIVD_W-1:0] quotient
);
   import tilt_pkg::*;

   localparam int CNT_W = $clog2(DIV_CYCLES + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DIVS_W-1:0]   rem_ff, rem_in;
   logic [DIVD_W-1:0]   work_ff, work_in;
   logic [DIVS_W-1:0]   dvs_ff, dvs_in;

   logic [DIVS_W-1:0]   r_step;
   logic [DIVD_W-1:0]   w_step;
   logic [DIVS_W:0]     trial;

   always_comb begin
      r_step = rem_ff;
      w_step = work_ff;
      trial  = '0;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial  = {r_step, w_step[DIVD_W-1]};
         w_step = {w_step[DIVD_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            r_step    = DIVS_W'(trial - {1'b0, dvs_ff});
            w_step[0] = 1'b1;
         end else begin
            r_step = trial[DIVS_W-1:0];
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      work_in = work_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         work_in = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = r_step;
         work_in = w_step;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      work_ff <= work_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

### rtl/tilt_front.sv
// front end: takes samples and flags whether the angles must be recomputed
module tilt_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [tilt_pkg::SAMPLE_W-1:0] req_accel_x,
   input  logic signed [tilt_pkg::SAMPLE_W-1:0] req_accel_y,
   input  logic signed [tilt_pkg::SAMPLE_W-1:0] req_accel_z,
   input  logic [tilt_pkg::CSR_W-1:0]        change_threshold,
   input  tilt_pkg::tilt_qstat_type          qstat,
   output logic                              push,
   output tilt_pkg::tilt_item_type           item
);
   import tilt_pkg::*;

   logic signed [SAMPLE_W-1:0] last_x_ff, last_x_in;
   logic signed [SAMPLE_W-1:0] last_y_ff, last_y_in;
   logic signed [SAMPLE_W-1:0] last_z_ff, last_z_in;

   logic signed [SAMPLE_W:0] dx, dy, dz;
   logic [SAMPLE_W:0]        mx, my, mz;
   logic [SAMPLE_W:0]        th;
   logic                     changed;

   always_comb begin
      dx = (SAMPLE_W+1)'(req_accel_x) - (SAMPLE_W+1)'(last_x_ff);
      dy = (SAMPLE_W+1)'(req_accel_y) - (SAMPLE_W+1)'(last_y_ff);
      dz = (SAMPLE_W+1)'(req_accel_z) - (SAMPLE_W+1)'(last_z_ff);
      mx = dx[SAMPLE_W] ? (SAMPLE_W+1)'(-dx) : (SAMPLE_W+1)'(dx);
      my = dy[SAMPLE_W] ? (SAMPLE_W+1)'(-dy) : (SAMPLE_W+1)'(dy);
      mz = dz[SAMPLE_W] ? (SAMPLE_W+1)'(-dz) : (SAMPLE_W+1)'(dz);
      th = (SAMPLE_W+1)'(change_threshold);
      changed = (mx >= th) || (my >= th) || (mz >= th);
   end

   assign req_stall    = qstat.full;
   assign push         = req_valid && !qstat.full;
   assign item.x       = req_accel_x;
   assign item.y       = req_accel_y;
   assign item.z       = req_accel_z;
   assign item.changed = changed;

   always_comb begin
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      last_z_in = last_z_ff;
      if (push && changed) begin
         last_x_in = req_accel_x;
         last_y_in = req_accel_y;
         last_z_in = req_accel_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff <= '0;
         last_y_ff <= '0;
         last_z_ff <= '0;
      end else begin
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
         last_z_ff <= last_z_in;
      end
   end

endmodule

### rtl/tilt_queue.sv
// short queue of classified samples between front and back
module tilt_queue #(
   parameter int DEPTH = tilt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  tilt_pkg::tilt_item_type item,
   input  logic                    pop,
   output tilt_pkg::tilt_item_type head,
   output tilt_pkg::tilt_qstat_type qstat
);
   import tilt_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tilt_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= item;
      end
   end

   assign head        = mem_ff[rd_ff];
   assign qstat.empty = (cnt_ff == '0);
   assign qstat.full  = (cnt_ff == CNT_W'(DEPTH));

endmodule

### rtl/tilt_back.sv
// back end: normalize, square root and atan2 on a shared divider, degree scaling by reciprocal multiply
`include "tilt_angle_from_accel_assert.svh"

module tilt_back #(
   parameter int SQRT_STEPS = tilt_pkg::SQRT_STEPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [tilt_pkg::CSR_W-1:0]         g_scale,
   input  tilt_pkg::tilt_item_type            head,
   input  tilt_pkg::tilt_qstat_type           qstat,
   output logic                               pop,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic signed [tilt_pkg::ANGLE_W-1:0] rsp_roll_angle,
   output logic signed [tilt_pkg::ANGLE_W-1:0] rsp_pitch_angle,
   output logic                               rsp_recomputed
);
   import tilt_pkg::*;

   localparam int STEP_W = $clog2(SQRT_STEPS + 1);

   tilt_state_type state_ff, state_in;

   logic signed [NORM_W-1:0]  norm_ff [3];
   logic signed [NORM_W-1:0]  norm_in [3];
   logic [1:0]                idx_ff, idx_in;
   logic [ROOT_W-1:0]         s_ff, s_in;
   logic [ROOT_W-1:0]         a_ff, a_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      pass_ff, pass_in;
   logic                      numneg_ff, numneg_in;
   logic                      xneg_ff, xneg_in;
   logic                      yneg_ff, yneg_in;
   logic signed [17:0]        r_ff, r_in;
   logic [16:0]               r2_ff, r2_in;
   logic signed [17:0]        t_ff, t_in;
   logic signed [ANG_W-1:0]   ang_ff, ang_in;
   logic [ANGLE_W-1:0]        dq0_ff, dq0_in;
   logic [18:0]               drem_ff, drem_in;
   logic signed [ANGLE_W-1:0] roll_ff, roll_in;
   logic signed [ANGLE_W-1:0] pitch_ff, pitch_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_W-1:0] rsp_roll_ff, rsp_roll_in;
   logic signed [ANGLE_W-1:0] rsp_pitch_ff, rsp_pitch_in;
   logic                      rsp_rec_ff, rsp_rec_in;

   logic                      div_start;
   logic [DIVD_W-1:0]         div_dividend;
   logic [DIVS_W-1:0]         div_divisor;
   logic                      div_done;
   logic [DIVD_W-1:0]         div_q;

   logic                      out_free;
   logic                      div_wait;
   logic signed [SAMPLE_W-1:0] raw;
   logic [SAMPLE_W:0]         raw_mag;
   logic [CSR_W-1:0]          cpg_fix;
   logic [ROOT_W-1:0]         a_fix;
   logic signed [AT_W-1:0]    at_y, at_x, ay, num, den, num_mag;
   logic signed [2*NORM_W-1:0] sq;
   logic [ROOT_W:0]           root_sum;
   logic signed [35:0]        rr, tr;
   logic signed [35:0]        tr_adj;
   logic [30:0]               c1r2;
   logic signed [ANG_W-1:0]   ang_raw, ang_mag;
   logic [ANG_W-2:0]          ang_m;
   logic [48:0]               deg_prod;
   logic [35:0]               deg_num, deg_sub;
   logic [ANGLE_W-1:0]        deg_q;
   logic [DIVD_W-1:0]         norm_q_mag;
   logic [ANGLE_W-1:0]        deg_mag;
   logic signed [ANGLE_W-1:0] deg_val;

   tilt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // shared operand paths
   always_comb begin
      case (idx_ff)
         2'd0:    raw = head.x;
         2'd1:    raw = head.y;
         default: raw = head.z;
      endcase
      raw_mag = raw[SAMPLE_W-1] ? (SAMPLE_W+1)'(-(SAMPLE_W+1)'(raw))
                                : (SAMPLE_W+1)'(raw);
      cpg_fix = (g_scale == '0) ? CSR_W'(1) : g_scale;
      a_fix   = (a_ff == '0) ? ROOT_W'(1) : a_ff;
      at_y    = pass_ff ? AT_W'(norm_ff[0]) : AT_W'(norm_ff[1]);
      at_x    = pass_ff ? AT_W'({1'b0, a_ff}) : AT_W'(norm_ff[2]);
      ay      = (at_y < 0 ? -at_y : at_y) + AT_W'(1);
      num     = (at_x < 0) ? (at_x + ay) : (at_x - ay);
      den     = (at_x < 0) ? (ay - at_x) : (at_x + ay);
      num_mag = (num < 0) ? -num : num;
      sq      = (idx_ff == 2'd1) ? norm_ff[1] * norm_ff[1] : norm_ff[2] * norm_ff[2];
      root_sum = (ROOT_W+1)'(a_fix) + (ROOT_W+1)'(div_q);
      rr      = r_ff * r_ff;
      c1r2    = 31'(ATAN_C1) * 31'(r2_ff);
      tr      = t_ff * r_ff;
      tr_adj  = tr + ((tr < 0) ? 36'sd65535 : 36'sd0);
      ang_raw = (xneg_ff ? ANG_W'(THREE_QTR_PI_Q) : ANG_W'(QTR_PI_Q))
                + ANG_W'(tr_adj >>> Q_FRAC);
      ang_mag = (ang_ff < 0) ? -ang_ff : ang_ff;
      ang_m   = ang_mag[ANG_W-2:0];
      // degree scaling by reciprocal, then one compare and subtract step
      deg_prod = 49'(ang_m) * 49'(DEG_RECIP);
      deg_num  = 36'(ang_m) * 36'(HALF_TURN_OUT);
      deg_sub  = 36'(dq0_ff) * 36'(PI_Q);
      deg_q    = dq0_ff + ((drem_ff >= 19'(PI_Q)) ? ANGLE_W'(1) : ANGLE_W'(0));
      norm_q_mag = div_q;
      deg_mag = (deg_q > ANGLE_W'(HALF_TURN_OUT)) ? ANGLE_W'(HALF_TURN_OUT) : deg_q;
      deg_val = ang_ff[ANG_W-1] ? -$signed(deg_mag) : $signed(deg_mag);
      div_wait = state_ff inside {S_NORM_WAIT, S_SQRT_WAIT, S_AT_WAIT};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (!qstat.empty) begin
               state_in = head.changed ? S_NORM_DIV : S_OUT;
            end
         end
         S_NORM_DIV:  state_in = S_NORM_WAIT;
         S_NORM_WAIT: begin
            if (div_done) begin
               state_in = (idx_ff == 2'd2) ? S_SQ_Y : S_NORM_DIV;
            end
         end
         S_SQ_Y:      state_in = S_SQ_Z;
         S_SQ_Z:      state_in = S_SQRT_DIV;
         S_SQRT_DIV:  state_in = S_SQRT_WAIT;
         S_SQRT_WAIT: begin
            if (div_done) begin
               state_in = (step_ff == STEP_W'(SQRT_STEPS - 1)) ? S_AT_DIV : S_SQRT_DIV;
            end
         end
         S_AT_DIV:    state_in = S_AT_WAIT;
         S_AT_WAIT: begin
            if (div_done) begin
               state_in = S_AT_R2;
            end
         end
         S_AT_R2:     state_in = S_AT_T;
         S_AT_T:      state_in = S_AT_TR;
         S_AT_TR:     state_in = S_DEG_MUL;
         S_DEG_MUL:   state_in = S_DEG_REM;
         S_DEG_REM:   state_in = S_DEG_FIX;
         S_DEG_FIX:   state_in = pass_ff ? S_OUT : S_AT_DIV;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         norm_in[i] = norm_ff[i];
      end
      idx_in     = idx_ff;
      s_in       = s_ff;
      a_in       = a_ff;
      step_in    = step_ff;
      pass_in    = pass_ff;
      numneg_in  = numneg_ff;
      xneg_in    = xneg_ff;
      yneg_in    = yneg_ff;
      r_in       = r_ff;
      r2_in      = r2_ff;
      t_in       = t_ff;
      ang_in     = ang_ff;
      dq0_in     = dq0_ff;
      drem_in    = drem_ff;
      roll_in    = roll_ff;
      pitch_in   = pitch_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_roll_in  = rsp_roll_ff;
      rsp_pitch_in = rsp_pitch_ff;
      rsp_rec_in   = rsp_rec_ff;
      pop          = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      case (state_ff)
         S_IDLE: begin
            idx_in  = 2'd0;
            pass_in = 1'b0;
         end
         S_NORM_DIV: begin
            div_start    = 1'b1;
            div_dividend = DIVD_W'({raw_mag, 16'b0});
            div_divisor  = DIVS_W'(cpg_fix);
         end
         S_NORM_WAIT: begin
            if (div_done) begin
               if (raw[SAMPLE_W-1]) begin
                  norm_in[idx_ff] = (norm_q_mag > DIVD_W'(NORM_MIN_MAG))
                     ? -NORM_W'(NORM_MIN_MAG) : -NORM_W'(norm_q_mag);
               end else begin
                  norm_in[idx_ff] = (norm_q_mag > DIVD_W'(NORM_MAX))
                     ? NORM_W'(NORM_MAX) : NORM_W'(norm_q_mag);
               end
               idx_in = (idx_ff == 2'd2) ? 2'd1 : idx_ff + 2'd1;
            end
         end
         S_SQ_Y: begin
            s_in   = ROOT_W'(sq[2*NORM_W-1:Q_FRAC]);
            idx_in = 2'd2;
         end
         S_SQ_Z: begin
            s_in    = s_ff + ROOT_W'(sq[2*NORM_W-1:Q_FRAC]);
            a_in    = ROOT_W'(1 << Q_FRAC);
            step_in = '0;
         end
         S_SQRT_DIV: begin
            div_start    = 1'b1;
            div_dividend = DIVD_W'({s_ff, 16'b0});
            div_divisor  = DIVS_W'(a_fix);
         end
         S_SQRT_WAIT: begin
            if (div_done) begin
               a_in    = ROOT_W'(root_sum >> 1);
               step_in = step_ff + 1'b1;
            end
         end
         S_AT_DIV: begin
            div_start    = 1'b1;
            div_dividend = DIVD_W'({num_mag[DIVS_W-1:0], 16'b0});
            div_divisor  = DIVS_W'(den);
            numneg_in    = num[AT_W-1];
            xneg_in      = at_x[AT_W-1];
            yneg_in      = at_y[AT_W-1];
         end
         S_AT_WAIT: begin
            if (div_done) begin
               r_in = numneg_ff ? -18'(div_q) : 18'(div_q);
            end
         end
         S_AT_R2: r2_in = rr[32:16];
         S_AT_T:  t_in = $signed({3'b0, c1r2[30:16]}) - 18'(ATAN_C2);
         S_AT_TR: ang_in = yneg_ff ? -ang_raw : ang_raw;
         S_DEG_MUL: dq0_in = deg_prod[DEG_SHIFT+ANGLE_W-1:DEG_SHIFT];
         S_DEG_REM: drem_in = deg_num[18:0] - deg_sub[18:0];
         S_DEG_FIX: begin
            if (pass_ff) begin
               pitch_in = deg_val;
            end else begin
               roll_in = deg_val;
               pass_in = 1'b1;
            end
         end
         S_OUT: begin
            if (out_free) begin
               pop          = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_roll_in  = roll_ff;
               rsp_pitch_in = pitch_ff;
               rsp_rec_in   = head.changed;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         roll_ff      <= '0;
         pitch_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         roll_ff      <= roll_in;
         pitch_ff     <= pitch_in;
      end
      for (int i = 0; i < 3; i++) begin
         norm_ff[i] <= norm_in[i];
      end
      idx_ff       <= idx_in;
      s_ff         <= s_in;
      a_ff         <= a_in;
      step_ff      <= step_in;
      pass_ff      <= pass_in;
      numneg_ff    <= numneg_in;
      xneg_ff      <= xneg_in;
      yneg_ff      <= yneg_in;
      r_ff         <= r_in;
      r2_ff        <= r2_in;
      t_ff         <= t_in;
      ang_ff       <= ang_in;
      dq0_ff       <= dq0_in;
      drem_ff      <= drem_in;
      rsp_roll_ff  <= rsp_roll_in;
      rsp_pitch_ff <= rsp_pitch_in;
      rsp_rec_ff   <= rsp_rec_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_angle  = rsp_roll_ff;
   assign rsp_pitch_angle = rsp_pitch_ff;
   assign rsp_recomputed  = rsp_rec_ff;

   `TILT_ASSERT_NOW(a_busy_has_item, clock, reset, state_ff != S_IDLE, !qstat.empty)
   `TILT_ASSERT_NOW(a_done_while_waiting, clock, reset, div_done, div_wait)
   `TILT_ASSERT_NEXT(a_pop_loads_result, clock, reset, pop, rsp_valid_ff && rsp_rec_ff == $past(head.changed))

endmodule

### test/tb_top.sv
// self-checking testbench for the accelerometer tilt angle block
`timescale 1ns / 100ps

module tb_top;
   import tilt_pkg::*;

   localparam int  SQRT_ITERS  = SQRT_STEPS_DEF;
   localparam int  CYCLE_LIMIT = 4000000;
   localparam int  DRAIN_WAIT  = 300;

   typedef struct {
      logic signed [ANGLE_W-1:0] roll;
      logic signed [ANGLE_W-1:0] pitch;
      logic                      recomputed;
   } angle_result_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic signed [SAMPLE_W-1:0]  req_accel_x;
   logic signed [SAMPLE_W-1:0]  req_accel_y;
   logic signed [SAMPLE_W-1:0]  req_accel_z;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic signed [ANGLE_W-1:0]   rsp_roll_angle;
   logic signed [ANGLE_W-1:0]   rsp_pitch_angle;
   logic                        rsp_recomputed;
   logic                        csr_write_enable;
   tilt_csr_type                csr_index;
   logic [CSR_W-1:0]            csr_write_data;

   angle_result_type expected_angles[$];
   int            error_count;
   int            cycle_count;
   int            hold_left;
   int            stall_left;
   bit            quiet;

   // predictor state
   int unsigned   thresh_cur;
   int unsigned   cpg_cur;
   int            last_x, last_y, last_z;
   int            held_roll, held_pitch;
   int            sent_x, sent_y, sent_z;

   tilt_angle_from_accel u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_accel_x      (req_accel_x),
      .req_accel_y      (req_accel_y),
      .req_accel_z      (req_accel_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_roll_angle   (rsp_roll_angle),
      .rsp_pitch_angle  (rsp_pitch_angle),
      .rsp_recomputed   (rsp_recomputed),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint norm_axis(int raw);
      longint d;
      longint q;
      d = (cpg_cur == 0) ? 1 : longint'(cpg_cur);
      q = (longint'(raw) * 65536) / d;
      if (q > NORM_MAX) q = NORM_MAX;
      if (q < -longint'(NORM_MIN_MAG)) q = -longint'(NORM_MIN_MAG);
      return q;
   endfunction

   function automatic longint atan2_q16(longint y, longint x);
      longint ay, r, base, r2, t, ang;
      ay = ((y < 0) ? -y : y) + 1;
      if (x < 0) begin
         r = ((x + ay) * 65536) / (ay - x);
         base = THREE_QTR_PI_Q;
      end else begin
         r = ((x - ay) * 65536) / (x + ay);
         base = QTR_PI_Q;
      end
      r2 = (r * r) / 65536;
      t = (ATAN_C1 * r2) / 65536 - ATAN_C2;
      ang = base + (t * r) / 65536;
      return (y < 0) ? -ang : ang;
   endfunction

   function automatic longint root_q16(longint s);
      longint a;
      a = 65536;
      for (int i = 0; i < SQRT_ITERS; i++) begin
         if (a <= 0) a = 1;
         a = (a + (s * 65536) / a) / 2;
      end
      return a;
   endfunction

   function automatic int deg_out(longint ang);
      longint v;
      v = (ang * HALF_TURN_OUT) / PI_Q;
      if (v > HALF_TURN_OUT) v = HALF_TURN_OUT;
      if (v < -HALF_TURN_OUT) v = -HALF_TURN_OUT;
      return int'(v);
   endfunction

   function automatic int iabs(int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic angle_result_type predict_tilt(int x, int y, int z);
      angle_result_type res;
      longint nx, ny, nz, s;
      int th;
      bit changed;
      th = int'(thresh_cur);
      changed = iabs(x - last_x) >= th || iabs(y - last_y) >= th || iabs(z - last_z) >= th;
      if (changed) begin
         nx = norm_axis(x);
         ny = norm_axis(y);
         nz = norm_axis(z);
         s = (ny * ny) / 65536 + (nz * nz) / 65536;
         held_roll = deg_out(atan2_q16(ny, nz));
         held_pitch = deg_out(atan2_q16(nx, root_q16(s)));
         last_x = x;
         last_y = y;
         last_z = z;
      end
      res.roll = held_roll[ANGLE_W-1:0];
      res.pitch = held_pitch[ANGLE_W-1:0];
      res.recomputed = changed;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 5);
   endfunction

   // result checker and receiver stall
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_angles.size() == 0) begin
               report_mismatch("unexpected item", 0, 0);
            end else begin
               angle_result_type e;
               e = expected_angles.pop_front();
               if (rsp_roll_angle !== e.roll) report_mismatch("roll", rsp_roll_angle, e.roll);
               if (rsp_pitch_angle !== e.pitch)
                  report_mismatch("pitch", rsp_pitch_angle, e.pitch);
               if (rsp_recomputed !== e.recomputed)
                  report_mismatch("recomputed", rsp_recomputed, e.recomputed);
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(99) < 25) begin
            stall_left <= ($urandom_range(99) < 90) ? $urandom_range(2, 0)
                                                    : $urandom_range(60, 10);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_sample(int x, int y, int z);
      int gap;
      req_valid <= 1'b1;
      req_accel_x <= x[SAMPLE_W-1:0];
      req_accel_y <= y[SAMPLE_W-1:0];
      req_accel_z <= z[SAMPLE_W-1:0];
      do @(posedge clock); while (req_stall);
      expected_angles.push_back(predict_tilt(x, y, z));
      sent_x = x;
      sent_y = y;
      sent_z = z;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_angles.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(tilt_csr_type idx, int unsigned value);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[CSR_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_CHANGE_THRESHOLD) thresh_cur = value & 32'h7fff;
      else cpg_cur = value & 32'h7fff;
   endtask

   function automatic int clip16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic int rand16();
      return int'($signed(16'($urandom())));
   endfunction

   function automatic int near_axis(int v);
      int span;
      span = 2 * int'(thresh_cur) + 2;
      if (span > 40000) return rand16();
      return clip16(v + $urandom_range(2 * span, 0) - span);
   endfunction

   task automatic test_directed();
      send_sample(10, -10, 5);
      send_sample(-32768, -32768, -32768);
      send_sample(32767, 32767, 32767);
      send_sample(0, 0, 0);
      send_sample(32767, -32768, 0);
      send_sample(-32768, 32767, -1);
      send_sample(0, 0, -16384);
      send_sample(16384, 0, 0);
      send_sample(-16384, 1, -1);
      send_sample(-16320, 1, -1);
      send_sample(-16321, 1, -1);
      write_csr(CSR_CHANGE_THRESHOLD, 0);
      send_sample(-16321, 1, -1);
      send_sample(0, 0, 0);
      write_csr(CSR_G_SCALE, 0);
      send_sample(1, -1, 32767);
      send_sample(-32768, 5, -7);
      write_csr(CSR_G_SCALE, 1);
      send_sample(32767, -32768, 2);
      write_csr(CSR_G_SCALE, 32767);
      send_sample(-32768, 32767, -32768);
      write_csr(CSR_CHANGE_THRESHOLD, 32767);
      send_sample(0, 0, 0);
      send_sample(32767, 32767, 32767);
      send_sample(-1, -1, -1);
   endtask

   task automatic test_random_phase(int unsigned th, int unsigned cpg, int count);
      int r;
      write_csr(CSR_CHANGE_THRESHOLD, th);
      write_csr(CSR_G_SCALE, cpg);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         quiet = (i % 100) >= 80;
         if (r < 45) send_sample(near_axis(sent_x), near_axis(sent_y), near_axis(sent_z));
         else if (r < 90) send_sample(rand16(), rand16(), rand16());
         else send_sample(($urandom_range(1)) ? 32767 : -32768, rand16(),
                          ($urandom_range(1)) ? 0 : rand16());
      end
      quiet = 0;
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_left = 600;
      quiet = 1;
      for (int i = 0; i < 12; i++) send_sample(rand16(), rand16(), rand16());
      quiet = 0;
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_accel_x = '0;
      req_accel_y = '0;
      req_accel_z = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_CHANGE_THRESHOLD;
      csr_write_data = '0;
      error_count = 0;
      cycle_count = 0;
      hold_left = 0;
      stall_left = 0;
      quiet = 0;
      thresh_cur = THRESH_RESET;
      cpg_cur = CPG_RESET;
      last_x = 0; last_y = 0; last_z = 0;
      held_roll = 0; held_pitch = 0;
      sent_x = 0; sent_y = 0; sent_z = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_phase(THRESH_RESET, CPG_RESET, 400);
      test_backpressure();
      test_random_phase(0, 4096, 300);
      test_random_phase(500, 1, 250);
      test_random_phase(32767, 32767, 200);
      test_random_phase(8, 0, 200);
      test_random_phase(2000, 1000, 300);

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
